// ===== src/dbrf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbrf_pkg
// Shared types, fixed-point constants and table builders of the range filter.
// ----------------------------------------------------------------------------
package dbrf_pkg;

  localparam int unsigned READING_W = 18;
  localparam int unsigned MEAN_W    = 18;
  localparam int unsigned INV_W     = 30;
  localparam int unsigned ETAB_W    = 33;
  localparam int unsigned LIK_W     = 30;
  localparam int unsigned U_W       = 28;
  localparam int unsigned Z_W       = 21;
  localparam int unsigned IDX_W     = 10;
  localparam int unsigned CNT_W     = 8;
  localparam int unsigned Q24_W     = 24;

  localparam logic [63:0] ONE_Q32     = 64'h0000_0001_0000_0000;
  localparam logic [63:0] LN2_Q32     = 64'd2977044472;
  localparam logic [63:0] MEAN_K1_Q16 = 64'd783497600;
  localparam logic [63:0] MEAN_K2_Q32 = 64'd4182614216;
  localparam logic [63:0] STD_K1_Q16  = 64'd365326;
  localparam logic [63:0] STD_K2_Q32  = 64'd604409858;

  localparam logic [CNT_W-1:0] PERIOD_RST = 8'd10;
  localparam logic [CNT_W-1:0] CNT_MAX    = 8'hFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_PASS1,
    ST_PASS2,
    ST_FIN
  } state_e;

  function automatic logic [63:0] div_u64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], a[i]};
      if (r >= {1'b0, b}) begin
        r    = r - {1'b0, b};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] mul_q32(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] hi;
    logic [63:0] lo;
    hi = (a >> 32) * b;
    lo = ((a & 64'h0000_0000_FFFF_FFFF) * b) >> 32;
    return hi + lo;
  endfunction

  function automatic logic [63:0] ln_q32(input logic [63:0] n);
    int unsigned e;
    logic [63:0] m;
    logic [63:0] s;
    logic [63:0] s2;
    logic [63:0] term;
    logic [63:0] acc;
    e = 0;
    for (int j = 0; j < 31; j++) begin
      if ((n >> (e + 1)) != 64'd0) e++;
    end
    m    = (n << 32) >> e;
    s    = div_u64((m - ONE_Q32) << 32, m + ONE_Q32);
    s2   = (s * s) >> 32;
    term = s;
    acc  = '0;
    for (int k = 0; k < 16; k++) begin
      acc  = acc + div_u64(term, 64'(2 * k + 1));
      term = (term * s2) >> 32;
    end
    return 64'(e) * LN2_Q32 + 2 * acc;
  endfunction

  function automatic logic [63:0] exp_neg_q32(input logic [63:0] y);
    logic [63:0] k;
    logic [63:0] r;
    logic [63:0] mag;
    logic signed [63:0] acc;
    k   = div_u64(y, LN2_Q32);
    r   = y - k * LN2_Q32;
    mag = ONE_Q32;
    acc = $signed(ONE_Q32);
    if (k >= 64'd63) return 64'd0;
    for (int n = 1; n <= 20; n++) begin
      mag = div_u64((mag * r) >> 32, 64'(n));
      if ((n % 2) == 1) acc = acc - $signed(mag);
      else acc = acc + $signed(mag);
    end
    if (acc < 0) acc = '0;
    return $unsigned(acc) >> k;
  endfunction

  function automatic logic [63:0] mean_at(input int unsigned i);
    logic [63:0] n;
    logic [63:0] ln10;
    logic [63:0] lnn;
    logic [63:0] lnd;
    logic [63:0] e;
    n    = 64'd10 + 64'(i);
    ln10 = ln_q32(64'd10);
    lnn  = ln_q32(n);
    lnd  = (lnn > ln10) ? lnn - ln10 : 64'd0;
    e    = exp_neg_q32(mul_q32(lnd, MEAN_K2_Q32));
    return (MEAN_K1_Q16 * e + (64'd1 << 43)) >> 44;
  endfunction

  function automatic logic [63:0] inv_std_at(input int unsigned i);
    logic [63:0] n;
    logic [63:0] dq;
    logic [63:0] es;
    n  = 64'd10 + 64'(i);
    dq = div_u64(n << 32, 64'd10);
    es = exp_neg_q32(mul_q32(dq, STD_K2_Q32));
    return div_u64(es << 16, STD_K1_Q16);
  endfunction

  function automatic logic [63:0] etab_at(input int unsigned k, input int unsigned depth);
    return exp_neg_q32(div_u64(64'(k) << 37, 64'(depth)));
  endfunction

endpackage

// ===== src/dbrf_lik.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbrf_lik
// Per-state likelihood pipeline: gaussian weight of one reading times prior.
// ----------------------------------------------------------------------------
module dbrf_lik #(
  parameter int unsigned STATES          = 591,
  parameter int unsigned PROB_BITS       = 24,
  parameter int unsigned EXP_TABLE_DEPTH = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_vld_i,
  input  logic [$clog2(STATES)-1:0]            in_addr_i,
  input  logic [dbrf_pkg::READING_W-1:0]       reading_i,
  input  logic [PROB_BITS-1:0]                 p_i,
  output logic                                 out_vld_o,
  output logic [$clog2(STATES)-1:0]            out_addr_o,
  output logic [PROB_BITS+16:0]                prod_o
);

  localparam int unsigned AW    = $clog2(STATES);
  localparam int unsigned KW    = $clog2(EXP_TABLE_DEPTH);
  localparam int unsigned PW    = PROB_BITS;
  localparam int unsigned PRODW = PROB_BITS + 17;
  localparam int unsigned ZDW   = dbrf_pkg::Z_W + KW + 1;
  localparam logic [KW:0] DEPTH = (KW + 1)'(EXP_TABLE_DEPTH);
  localparam logic [KW:0] KLAST = (KW + 1)'(EXP_TABLE_DEPTH - 1);
  localparam int unsigned NST   = 7;

  logic [dbrf_pkg::MEAN_W-1:0] mean_rom [STATES];
  logic [dbrf_pkg::INV_W-1:0]  inv_rom  [STATES];
  logic [dbrf_pkg::ETAB_W-1:0] etab_rom [EXP_TABLE_DEPTH];

  for (genvar g = 0; g < STATES; g++) begin : g_state_rom
    localparam logic [dbrf_pkg::MEAN_W-1:0] MV = dbrf_pkg::MEAN_W'(dbrf_pkg::mean_at(g));
    localparam logic [dbrf_pkg::INV_W-1:0]  IV = dbrf_pkg::INV_W'(dbrf_pkg::inv_std_at(g));
    assign mean_rom[g] = MV;
    assign inv_rom[g]  = IV;
  end

  for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_exp_rom
    localparam logic [dbrf_pkg::ETAB_W-1:0] EV =
      dbrf_pkg::ETAB_W'(dbrf_pkg::etab_at(g, EXP_TABLE_DEPTH));
    assign etab_rom[g] = EV;
  end

  logic          vld_q  [NST];
  logic [AW-1:0] addr_q [NST];

  logic [dbrf_pkg::MEAN_W-1:0] mean1_q;
  logic [dbrf_pkg::INV_W-1:0]  inv1_q, inv2_q, inv3_q, inv4_q, inv5_q;
  logic [PW-1:0]               p2_q, p3_q, p4_q, p5_q, p6_q;
  logic [dbrf_pkg::U_W-1:0]    u2_q;
  logic                        ok3_q, ok4_q, ok5_q;
  logic [dbrf_pkg::Z_W-1:0]    z3_q;
  logic [KW-1:0]               k4_q;
  logic [dbrf_pkg::ETAB_W-1:0] e5_q;
  logic [dbrf_pkg::LIK_W-1:0]  lik6_q;
  logic [PRODW-1:0]            prod7_q;

  logic [dbrf_pkg::READING_W-1:0] diff;
  logic [47:0]                    ud;
  logic [37:0]                    zz;
  logic [ZDW-1:0]                 zd;
  logic [KW:0]                    kf;
  logic [KW-1:0]                  kc;
  logic [62:0]                    le;
  logic [PW+29:0]                 pr;

  always_comb begin
    diff = (reading_i > mean1_q) ? reading_i - mean1_q : mean1_q - reading_i;
    ud   = 48'(diff) * 48'(inv1_q);
    zz   = 38'(u2_q[18:0]) * 38'(u2_q[18:0]);
    zd   = ZDW'(z3_q) * ZDW'(DEPTH);
    kf   = zd[dbrf_pkg::Z_W +: KW + 1];
    kc   = (kf >= DEPTH) ? KLAST[KW-1:0] : kf[KW-1:0];
    le   = 63'(e5_q) * 63'(inv5_q);
    pr   = (PW + 30)'(lik6_q) * (PW + 30)'(p6_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NST; s++) vld_q[s] <= 1'b0;
    end else begin
      vld_q[0] <= in_vld_i;
      for (int s = 1; s < NST; s++) vld_q[s] <= vld_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q[0] <= in_addr_i;
    for (int s = 1; s < NST; s++) addr_q[s] <= addr_q[s-1];
    mean1_q <= mean_rom[in_addr_i];
    inv1_q  <= inv_rom[in_addr_i];
    // stage 2: scaled distance
    u2_q    <= ud[20 +: dbrf_pkg::U_W];
    inv2_q  <= inv1_q;
    p2_q    <= p_i;
    // stage 3: squared
    ok3_q   <= (u2_q[dbrf_pkg::U_W-1:19] == '0);
    z3_q    <= zz[37:17];
    inv3_q  <= inv2_q;
    p3_q    <= p2_q;
    // stage 4: table index
    ok4_q   <= ok3_q;
    k4_q    <= kc;
    inv4_q  <= inv3_q;
    p4_q    <= p3_q;
    // stage 5: table read
    ok5_q   <= ok4_q;
    e5_q    <= etab_rom[k4_q];
    inv5_q  <= inv4_q;
    p5_q    <= p4_q;
    // stage 6: likelihood
    lik6_q  <= ok5_q ? le[32 +: dbrf_pkg::LIK_W] : '0;
    p6_q    <= p5_q;
    // stage 7: weighted prior
    prod7_q <= pr[13 +: PRODW];
  end

  assign out_vld_o  = vld_q[NST-1];
  assign out_addr_o = addr_q[NST-1];
  assign prod_o     = prod7_q;

endmodule

// ===== src/dbrf_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbrf_div
// Pipelined restoring divider, one quotient bit per stage, for normalization.
// ----------------------------------------------------------------------------
module dbrf_div #(
  parameter int unsigned STATES    = 591,
  parameter int unsigned PROB_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_vld_i,
  input  logic [$clog2(STATES)-1:0]     in_addr_i,
  input  logic [PROB_BITS+16:0]         in_num_i,
  input  logic [PROB_BITS+17:0]         den_i,
  output logic                          out_vld_o,
  output logic [$clog2(STATES)-1:0]     out_addr_o,
  output logic [PROB_BITS-1:0]          out_q_o
);

  localparam int unsigned AW   = $clog2(STATES);
  localparam int unsigned PW   = PROB_BITS;
  localparam int unsigned SUMW = PROB_BITS + 18;

  logic            vld_q [PW];
  logic [AW-1:0]   adr_q [PW];
  logic [SUMW-1:0] rem_q [PW];
  logic [PW-1:0]   quo_q [PW];
  logic [SUMW-1:0] rem_d [PW];
  logic [PW-1:0]   quo_d [PW];
  logic [SUMW-1:0] src_rem [PW];
  logic [PW-1:0]   src_quo [PW];

  for (genvar j = 0; j < PW; j++) begin : g_stage
    logic [SUMW:0] t;
    if (j == 0) begin : g_first
      assign src_rem[j] = SUMW'(in_num_i);
      assign src_quo[j] = '0;
    end else begin : g_next
      assign src_rem[j] = rem_q[j-1];
      assign src_quo[j] = quo_q[j-1];
    end
    always_comb begin
      t = {src_rem[j], 1'b0};
      if (t >= {1'b0, den_i}) begin
        rem_d[j] = SUMW'(t - {1'b0, den_i});
        quo_d[j] = {src_quo[j][PW-2:0], 1'b1};
      end else begin
        rem_d[j] = t[SUMW-1:0];
        quo_d[j] = {src_quo[j][PW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < PW; s++) vld_q[s] <= 1'b0;
    end else begin
      vld_q[0] <= in_vld_i;
      for (int s = 1; s < PW; s++) vld_q[s] <= vld_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    adr_q[0] <= in_addr_i;
    for (int s = 1; s < PW; s++) adr_q[s] <= adr_q[s-1];
    for (int s = 0; s < PW; s++) begin
      rem_q[s] <= rem_d[s];
      quo_q[s] <= quo_d[s];
    end
  end

  assign out_vld_o  = vld_q[PW-1];
  assign out_addr_o = adr_q[PW-1];
  assign out_q_o    = quo_q[PW-1];

endmodule

// ===== src/discrete_bayes_range_filter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// discrete_bayes_range_filter_core
// Histogram filter over STATES distance bins, probabilities held in one RAM.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) takes one item at a time: func_i 0 is
// an update with reading_i (restart_i forces a uniform prior first), func_i 1
// reads the probability of entry_index_i. Each item gives one result on the
// output channel (out_valid_o/out_ready_i). cfg_valid_i/cfg_data_i write
// reset_period; cfg_ready_o is always high.
// An update runs two passes over the probability RAM through the likelihood
// pipeline (7 stages): a sum pass, then a normalize pass through a divider of
// PROB_BITS stages. A degenerate update, with a zero sum, stops after the
// sum pass.
// One item is in work at a time; in_ready_o is high while idle, also while
// a finished result waits on a stalled receiver. A finishing item waits in
// its last state until the output register is free.
// Reset leaves the store reading as uniform through a flag, so no clearing
// pass is run; the counter clears and reset_period returns to 10.
// ----------------------------------------------------------------------------
module discrete_bayes_range_filter_core #(
  parameter int unsigned STATES          = 591,
  parameter int unsigned PROB_BITS       = 24,
  parameter int unsigned EXP_TABLE_DEPTH = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [dbrf_pkg::CNT_W-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                func_i,
  input  logic [dbrf_pkg::READING_W-1:0]      reading_i,
  input  logic                                restart_i,
  input  logic [dbrf_pkg::IDX_W-1:0]          entry_index_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [dbrf_pkg::IDX_W-1:0]          out_index_o,
  output logic [dbrf_pkg::Q24_W-1:0]          probability_o,
  output logic                                degenerate_o,
  output logic [dbrf_pkg::CNT_W-1:0]          updates_done_o
);

  localparam int unsigned AW    = $clog2(STATES);
  localparam int unsigned PW    = PROB_BITS;
  localparam int unsigned PRODW = PROB_BITS + 17;
  localparam int unsigned SUMW  = PROB_BITS + 18;
  localparam int unsigned DOWN  = (PROB_BITS > 24) ? PROB_BITS - 24 : 0;
  localparam int unsigned UP    = (PROB_BITS < 24) ? 24 - PROB_BITS : 0;
  localparam logic [AW-1:0] LAST = AW'(STATES - 1);
  localparam logic [PW-1:0] UNIFORM =
    PW'(((64'd1 << PROB_BITS) + 64'(STATES / 2)) / 64'(STATES));

  dbrf_pkg::state_e state_q, state_d;

  logic                           uni_q, uni_d;
  logic                           pass_uni_q, pass_uni_d;
  logic [dbrf_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic [dbrf_pkg::CNT_W-1:0]     period_q;
  logic [dbrf_pkg::READING_W-1:0] reading_q, reading_d;
  logic                           iss_on_q, iss_on_d;
  logic [AW-1:0]                  iss_q, iss_d;
  logic [AW-1:0]                  ret_q, ret_d;
  logic [SUMW-1:0]                sum_q, sum_d;
  logic [SUMW-1:0]                sum_nxt;
  logic                           deg_q, deg_d;
  logic [dbrf_pkg::IDX_W-1:0]     rd_idx_q, rd_idx_d;
  logic                           rd_ok_q, rd_ok_d;
  logic                           ovld_q, ovld_d;
  logic [dbrf_pkg::IDX_W-1:0]     oidx_q, oidx_d;
  logic [dbrf_pkg::Q24_W-1:0]     oprob_q, oprob_d;
  logic                           odeg_q, odeg_d;
  logic [dbrf_pkg::CNT_W-1:0]     ocnt_q, ocnt_d;

  logic [PW-1:0]   prob_mem [STATES];
  logic [PW-1:0]   rdata_q;
  logic            re;
  logic [AW-1:0]   ra;

  logic            lik_vld;
  logic [AW-1:0]   lik_addr;
  logic [PRODW-1:0] lik_prod;
  logic            div_vld;
  logic [AW-1:0]   div_addr;
  logic [PW-1:0]   div_q;

  logic [PW-1:0]    p_now;
  logic [PW-1:0]    p_lik;
  logic [PW+23:0]   p_wide;
  logic [dbrf_pkg::Q24_W-1:0] p24;
  logic             out_free;
  logic             start_uni;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == dbrf_pkg::ST_IDLE);
  assign out_free    = !ovld_q || out_ready_i;

  assign p_lik  = pass_uni_q ? UNIFORM : rdata_q;
  assign p_now  = uni_q ? UNIFORM : rdata_q;
  assign p_wide = ((PW + 24)'(p_now) >> DOWN) << UP;
  assign p24    = p_wide[dbrf_pkg::Q24_W-1:0];
  assign sum_nxt = sum_q + SUMW'(lik_prod);
  assign start_uni = restart_i || (cnt_q >= period_q);

  dbrf_lik #(
    .STATES          (STATES),
    .PROB_BITS       (PROB_BITS),
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_lik (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_vld_i   (iss_on_q),
    .in_addr_i  (iss_q),
    .reading_i  (reading_q),
    .p_i        (p_lik),
    .out_vld_o  (lik_vld),
    .out_addr_o (lik_addr),
    .prod_o     (lik_prod)
  );

  dbrf_div #(
    .STATES    (STATES),
    .PROB_BITS (PROB_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_vld_i   (lik_vld && (state_q == dbrf_pkg::ST_PASS2)),
    .in_addr_i  (lik_addr),
    .in_num_i   (lik_prod),
    .den_i      (sum_q),
    .out_vld_o  (div_vld),
    .out_addr_o (div_addr),
    .out_q_o    (div_q)
  );

  // probability store
  always_ff @(posedge clk_i) begin
    if (div_vld) prob_mem[div_addr] <= div_q;
    if (re) rdata_q <= prob_mem[ra];
  end

  always_comb begin
    state_d    = state_q;
    uni_d      = uni_q;
    pass_uni_d = pass_uni_q;
    cnt_d      = cnt_q;
    reading_d  = reading_q;
    iss_on_d   = iss_on_q;
    iss_d      = iss_q;
    ret_d      = ret_q;
    sum_d      = sum_q;
    deg_d      = deg_q;
    rd_idx_d   = rd_idx_q;
    rd_ok_d    = rd_ok_q;
    ovld_d     = ovld_q && !out_ready_i;
    oidx_d     = oidx_q;
    oprob_d    = oprob_q;
    odeg_d     = odeg_q;
    ocnt_d     = ocnt_q;
    re         = 1'b0;
    ra         = iss_q;

    if (iss_on_q) begin
      re    = 1'b1;
      iss_d = AW'(iss_q + 1'b1);
      if (iss_q == LAST) iss_on_d = 1'b0;
    end

    case (state_q)
      dbrf_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (func_i) begin
            re       = 1'b1;
            ra       = AW'(entry_index_i);
            rd_idx_d = entry_index_i;
            rd_ok_d  = (32'(entry_index_i) < STATES);
            state_d  = dbrf_pkg::ST_READ;
          end else begin
            pass_uni_d = uni_q || start_uni;
            if (start_uni) cnt_d = '0;
            reading_d  = reading_i;
            iss_d      = '0;
            iss_on_d   = 1'b1;
            ret_d      = '0;
            sum_d      = '0;
            state_d    = dbrf_pkg::ST_PASS1;
          end
        end
      end
      dbrf_pkg::ST_READ: begin
        if (out_free) begin
          ovld_d  = 1'b1;
          oidx_d  = rd_idx_q;
          oprob_d = rd_ok_q ? p24 : '0;
          odeg_d  = 1'b0;
          ocnt_d  = cnt_q;
          state_d = dbrf_pkg::ST_IDLE;
        end
      end
      dbrf_pkg::ST_PASS1: begin
        if (lik_vld) begin
          sum_d = sum_nxt;
          ret_d = AW'(ret_q + 1'b1);
          if (ret_q == LAST) begin
            if (sum_nxt == '0) begin
              uni_d   = 1'b1;
              cnt_d   = '0;
              deg_d   = 1'b1;
              state_d = dbrf_pkg::ST_FIN;
            end else begin
              deg_d    = 1'b0;
              iss_d    = '0;
              iss_on_d = 1'b1;
              ret_d    = '0;
              state_d  = dbrf_pkg::ST_PASS2;
            end
          end
        end
      end
      dbrf_pkg::ST_PASS2: begin
        if (div_vld) begin
          ret_d = AW'(ret_q + 1'b1);
          if (ret_q == LAST) begin
            uni_d = 1'b0;
            if (cnt_q != dbrf_pkg::CNT_MAX) cnt_d = cnt_q + 1'b1;
            state_d = dbrf_pkg::ST_FIN;
          end
        end
      end
      dbrf_pkg::ST_FIN: begin
        if (out_free) begin
          ovld_d  = 1'b1;
          oidx_d  = '0;
          oprob_d = '0;
          odeg_d  = deg_q;
          ocnt_d  = cnt_q;
          state_d = dbrf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dbrf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= dbrf_pkg::ST_IDLE;
      uni_q      <= 1'b1;
      pass_uni_q <= 1'b1;
      cnt_q      <= '0;
      period_q   <= dbrf_pkg::PERIOD_RST;
      iss_on_q   <= 1'b0;
      iss_q      <= '0;
      ret_q      <= '0;
      sum_q      <= '0;
      deg_q      <= 1'b0;
      rd_ok_q    <= 1'b0;
      ovld_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      uni_q      <= uni_d;
      pass_uni_q <= pass_uni_d;
      cnt_q      <= cnt_d;
      if (cfg_valid_i) period_q <= cfg_data_i;
      iss_on_q   <= iss_on_d;
      iss_q      <= iss_d;
      ret_q      <= ret_d;
      sum_q      <= sum_d;
      deg_q      <= deg_d;
      rd_ok_q    <= rd_ok_d;
      ovld_q     <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    reading_q <= reading_d;
    rd_idx_q  <= rd_idx_d;
    oidx_q    <= oidx_d;
    oprob_q   <= oprob_d;
    odeg_q    <= odeg_d;
    ocnt_q    <= ocnt_d;
  end

  assign out_valid_o    = ovld_q;
  assign out_index_o    = oidx_q;
  assign probability_o  = oprob_q;
  assign degenerate_o   = odeg_q;
  assign updates_done_o = ocnt_q;

`ifndef SYNTHESIS
  a_wr_in_pass2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_vld |-> state_q == dbrf_pkg::ST_PASS2)
    else $error("store write outside normalize pass");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !iss_on_q && !lik_vld && !div_vld)
    else $error("pipeline busy while idle");

  a_deg_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> out_index_o == '0 && probability_o == '0)
    else $error("degenerate flag on a read item");
`endif

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the range filter core: a directed table, then random
// range readings and reads, each checked against a bit-true histogram model.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned N_BINS = 591;
  localparam int unsigned P_BITS = 24;
  localparam int unsigned E_DEPTH = 1024;
  localparam bit FN_UPDATE = 1'b0;
  localparam bit FN_READ = 1'b1;
  localparam int unsigned N_RANDOM = 440;
  localparam int unsigned CALM_FROM = 380;
  localparam logic [dbrf_pkg::Q24_W-1:0] UNIFORM_Q24 = 24'd28388;

  typedef struct {
    logic [dbrf_pkg::IDX_W-1:0] idx;
    logic [dbrf_pkg::Q24_W-1:0] prob;
    logic                       deg;
    logic [dbrf_pkg::CNT_W-1:0] cnt;
  } result_t;

  typedef struct {
    bit                             func;
    bit [dbrf_pkg::READING_W-1:0]   reading;
    bit                             restart;
    bit [dbrf_pkg::IDX_W-1:0]       idx;
    bit                             typed;
    bit [dbrf_pkg::Q24_W-1:0]       e_prob;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [dbrf_pkg::CNT_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic func = 1'b0;
  logic [dbrf_pkg::READING_W-1:0] reading = '0;
  logic restart = 1'b0;
  logic [dbrf_pkg::IDX_W-1:0] entry_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [dbrf_pkg::IDX_W-1:0] out_index;
  logic [dbrf_pkg::Q24_W-1:0] probability;
  logic degenerate;
  logic [dbrf_pkg::CNT_W-1:0] updates_done;

  longint unsigned mean_rom[N_BINS];
  longint unsigned inv_std_rom[N_BINS];
  longint unsigned exp_rom[E_DEPTH];
  longint unsigned hist[N_BINS];
  longint unsigned weight[N_BINS];
  int unsigned upd_count;
  int unsigned period;

  result_t pending_q[$];
  row_t dir_q[$];
  int unsigned errors = 0;
  int unsigned sent = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  always #5 clk = ~clk;

  discrete_bayes_range_filter_core i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .func_i         (func),
    .reading_i      (reading),
    .restart_i      (restart),
    .entry_index_i  (entry_index),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .out_index_o    (out_index),
    .probability_o  (probability),
    .degenerate_o   (degenerate),
    .updates_done_o (updates_done)
  );

  function automatic longint unsigned ln_fix(longint unsigned n);
    int unsigned e;
    longint unsigned m, s, s2, term, acc;
    e = 0;
    acc = 0;
    while (e < 31 && (n >> (e + 1)) != 0) e++;
    m = (n << 32) >> e;
    s = ((m - 64'h1_0000_0000) << 32) / (m + 64'h1_0000_0000);
    s2 = (s * s) >> 32;
    term = s;
    for (int k = 0; k < 16; k++) begin
      acc += term / longint'(2 * k + 1);
      term = (term * s2) >> 32;
    end
    return longint'(e) * 64'd2977044472 + 2 * acc;
  endfunction

  function automatic longint unsigned exp_neg_fix(longint unsigned y);
    longint unsigned k, r, mag;
    longint acc;
    k = y / 64'd2977044472;
    r = y - k * 64'd2977044472;
    mag = 64'h1_0000_0000;
    acc = 64'h1_0000_0000;
    if (k >= 63) return 0;
    for (int n = 1; n <= 20; n++) begin
      mag = ((mag * r) >> 32) / longint'(n);
      if (n % 2 == 1) acc -= longint'(mag);
      else acc += longint'(mag);
    end
    if (acc < 0) acc = 0;
    return longint'(acc) >> k;
  endfunction

  function automatic longint unsigned q32_scale(longint unsigned a, longint unsigned b);
    return (a >> 32) * b + (((a & 64'hFFFF_FFFF) * b) >> 32);
  endfunction

  task automatic build_tables();
    longint unsigned ln10, lnn, lnd, e, es, n;
    ln10 = ln_fix(10);
    for (int i = 0; i < N_BINS; i++) begin
      n = 10 + i;
      lnn = ln_fix(n);
      lnd = lnn > ln10 ? lnn - ln10 : 0;
      e = exp_neg_fix(q32_scale(lnd, 64'd4182614216));
      es = exp_neg_fix(q32_scale((n << 32) / 10, 64'd604409858));
      mean_rom[i] = (64'd783497600 * e + (64'd1 << 43)) >> 44;
      inv_std_rom[i] = (es << 16) / 64'd365326;
    end
    for (int k = 0; k < E_DEPTH; k++)
      exp_rom[k] = exp_neg_fix((longint'(k) << 37) / E_DEPTH);
  endtask

  task automatic flatten_hist();
    for (int i = 0; i < N_BINS; i++) hist[i] = ((64'd1 << P_BITS) + N_BINS / 2) / N_BINS;
  endtask

  task automatic bayes_update(input longint unsigned rd, input bit rs, output bit deg);
    longint unsigned total, diff, u, z, k, lik;
    logic [127:0] wide;
    total = 0;
    if (rs || upd_count >= period) begin
      flatten_hist();
      upd_count = 0;
    end
    for (int i = 0; i < N_BINS; i++) begin
      diff = rd > mean_rom[i] ? rd - mean_rom[i] : mean_rom[i] - rd;
      u = (diff * inv_std_rom[i]) >> 20;
      lik = 0;
      if (u < (64'd8 << 16)) begin
        z = (u * u) >> 17;
        k = (z * E_DEPTH) >> 21;
        if (k >= E_DEPTH) k = E_DEPTH - 1;
        lik = (exp_rom[k] * inv_std_rom[i]) >> 32;
      end
      weight[i] = (lik * hist[i]) >> 13;
      total += weight[i];
    end
    deg = (total == 0);
    if (deg) begin
      flatten_hist();
      upd_count = 0;
    end else begin
      for (int i = 0; i < N_BINS; i++) begin
        wide = (128'(weight[i]) << P_BITS) / 128'(total);
        hist[i] = wide[63:0];
      end
      if (upd_count < 255) upd_count++;
    end
  endtask

  task automatic report(input string what, input longint unsigned got, input longint unsigned want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // one item through the input handshake, predicted at acceptance
  task automatic send_item(input row_t r);
    result_t res;
    bit deg;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid = 1'b1;
    func = r.func;
    reading = r.reading;
    restart = r.restart;
    entry_index = r.idx;
    do @(posedge clk); while (!in_ready);
    res = '{idx: '0, prob: '0, deg: 1'b0, cnt: '0};
    if (r.func == FN_UPDATE) begin
      bayes_update(r.reading, r.restart, deg);
      res.deg = deg;
    end else begin
      res.idx = r.idx;
      res.prob = r.idx < N_BINS ? hist[r.idx][dbrf_pkg::Q24_W-1:0] : '0;
    end
    res.cnt = upd_count[dbrf_pkg::CNT_W-1:0];
    if (r.typed) res.prob = r.e_prob;
    pending_q.push_back(res);
    sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_period(input logic [dbrf_pkg::CNT_W-1:0] val);
    while (pending_q.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    period = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic row_t mk(bit f, int unsigned rd, bit rs, int unsigned ix, bit ty,
                              int unsigned ep);
    row_t r;
    r = '{func: f, reading: dbrf_pkg::READING_W'(rd), restart: rs,
          idx: dbrf_pkg::IDX_W'(ix), typed: ty, e_prob: dbrf_pkg::Q24_W'(ep)};
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        report("unexpected result", 1, 0);
      end else begin
        want = pending_q.pop_front();
        if (out_index !== want.idx) report("out_index", out_index, want.idx);
        if (probability !== want.prob) report("probability", probability, want.prob);
        if (degenerate !== want.deg) report("degenerate", degenerate, want.deg);
        if (updates_done !== want.cnt) report("updates_done", updates_done, want.cnt);
      end
    end
  end

  // receiver: random stall bursts, one long hold-off
  initial begin
    int unsigned n;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        for (int c = 0; c < 3000; c++) @(negedge clk);
        hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 17);
        out_ready <= 1'b0;
        repeat (n) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #50ms;
    $display("tb: failure");
    $finish;
  end

  initial begin
    row_t r;
    int unsigned spot, w, tgt;
    build_tables();
    flatten_hist();
    upd_count = 0;
    period = 10;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed
    dir_q.push_back(mk(FN_READ, 0, 0, 0, 1, UNIFORM_Q24));
    dir_q.push_back(mk(FN_READ, 0, 0, 590, 1, UNIFORM_Q24));
    dir_q.push_back(mk(FN_READ, 0, 0, 591, 1, 0));
    dir_q.push_back(mk(FN_READ, 0, 0, 1023, 1, 0));
    dir_q.push_back(mk(FN_UPDATE, 0, 0, 0, 0, 0));
    dir_q.push_back(mk(FN_UPDATE, 262143, 0, 1023, 0, 0));
    dir_q.push_back(mk(FN_UPDATE, 16000, 1, 0, 0, 0));
    dir_q.push_back(mk(FN_UPDATE, 16100, 0, 0, 0, 0));
    dir_q.push_back(mk(FN_READ, 0, 0, 100, 0, 0));
    dir_q.push_back(mk(FN_UPDATE, 3600, 1, 0, 0, 0));
    dir_q.push_back(mk(FN_READ, 0, 0, 590, 0, 0));
    dir_q.push_back(mk(FN_UPDATE, 191283, 0, 0, 0, 0));
    dir_q.push_back(mk(FN_READ, 0, 1, 0, 0, 0));
    dir_q.push_back(mk(FN_UPDATE, 100000, 1, 0, 0, 0));
    dir_q.push_back(mk(FN_UPDATE, 1, 0, 0, 0, 0));
    foreach (dir_q[i]) send_item(dir_q[i]);

    for (int k = 0; k < N_RANDOM; k++) begin
      case (k)
        0:   write_period(8'd0);
        60:  write_period(8'd1);
        120: write_period(8'd255);
        240: write_period(8'd3);
        320: write_period(8'd10);
        default: ;
      endcase
      if (k == 150) hold_req = 1'b1;
      if (k == CALM_FROM) calm = 1'b1;
      if (k % 25 == 0) tgt = $urandom_range(0, N_BINS - 1);
      r = mk(FN_UPDATE, 0, 0, $urandom_range(0, 1023), 0, 0);
      if ($urandom_range(0, 9) < 4) begin
        r.func = FN_READ;
        if ($urandom_range(0, 4) != 0) r.idx = dbrf_pkg::IDX_W'($urandom_range(0, N_BINS - 1));
        r.restart = 1'($urandom_range(0, 1));
        r.reading = dbrf_pkg::READING_W'($urandom);
      end else begin
        r.restart = ($urandom_range(0, 9) == 0);
        spot = $urandom_range(0, 9);
        if (spot < 7) begin
          w = 32'(mean_rom[tgt] / 40 + 2);
          r.reading = dbrf_pkg::READING_W'(mean_rom[tgt] + $urandom_range(0, 2 * w) - w);
        end else if (spot < 9) begin
          r.reading = dbrf_pkg::READING_W'($urandom);
        end else begin
          r.reading = dbrf_pkg::READING_W'(mean_rom[$urandom_range(0, N_BINS - 1)]);
        end
      end
      send_item(r);
    end

    while (pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
